/* sv/rqc_pkg.sv */
// Shared types and constants for the rectangle quad clipper.
// No dependencies; every other file refers to it by scoped names.
package rqc_pkg;

  localparam int MAX_POINTS  = 8;
  localparam int PT_IDX_W    = 3;
  localparam int PT_CNT_W    = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int COORD_W     = 32;
  localparam int HALF_W      = 31;
  localparam int IN_DATA_W   = 320;
  localparam int OUT_DATA_W  = 72;
  localparam int MAG_W       = 33;
  localparam int PROD_W      = 66;
  localparam int QUO_W       = 34;
  localparam int DIV_CNT_W   = 6;

  typedef struct packed {
    logic [HALF_W-1:0]              half_x;
    logic [HALF_W-1:0]              half_y;
    logic [3:0][COORD_W-1:0]        corner_x;
    logic [3:0][COORD_W-1:0]        corner_y;
  } quad_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } point_t;

  // request to the crossing-point unit: base +/- (mag_a * mag_b / mag_d)
  typedef struct packed {
    logic                      start;
    logic [MAG_W-1:0]          mag_a;
    logic [MAG_W-1:0]          mag_b;
    logic [MAG_W-1:0]          mag_d;
    logic                      neg;
    logic signed [COORD_W-1:0] base;
  } div_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [COORD_W-1:0] value;
  } div_rsp_t;

  typedef enum logic [2:0] {
    DV_IDLE,
    DV_MUL,
    DV_ADD,
    DV_PREP,
    DV_DIV,
    DV_DONE
  } div_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOAD,
    BK_EDGE,
    BK_WAIT,
    BK_NEXT,
    BK_STAGE,
    BK_EMIT
  } back_state_t;

endpackage

/* sv/rqc_front.sv */
// Input side of the clipper: accepts quad words and queues them.
// Depends on rqc_pkg for the quad record.
module rqc_front #(
  parameter int DEPTH = rqc_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [rqc_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           q_valid,
  output rqc_pkg::quad_t                 q_data,
  input  logic                           q_pop
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rqc_pkg::quad_t  mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  rqc_pkg::quad_t  in_quad;
  logic            push, pop;

  // unpack the fields of the incoming word
  always_comb begin
    in_quad.half_x = in_tdata[30:0];
    in_quad.half_y = in_tdata[61:31];
    for (int k = 0; k < 4; k++) begin
      in_quad.corner_x[k] = in_tdata[62 + 64*k +: 32];
      in_quad.corner_y[k] = in_tdata[94 + 64*k +: 32];
    end
  end

  assign in_tready = (count_r != CW'(DEPTH));
  assign push      = in_tvalid && in_tready;
  assign pop       = q_pop && (count_r != '0);
  assign q_valid   = (count_r != '0);
  assign q_data    = mem_r[rd_ptr_r];

  // advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // store the word
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_quad;
    end
  end

endmodule

/* sv/rqc_div.sv */
// Crossing-point unit: base +/- trunc(a * b / d), one quotient bit per cycle.
// Depends on rqc_pkg for the request and response records.
module rqc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  rqc_pkg::div_req_t req,
  output rqc_pkg::div_rsp_t rsp
);

  rqc_pkg::div_state_t state_r, state_nxt;

  logic [rqc_pkg::MAG_W-1:0]          a_r, b_r, d_r;
  logic                               neg_r;
  logic signed [rqc_pkg::COORD_W-1:0] base_r;
  logic [rqc_pkg::PROD_W-1:0]         prod_r;
  logic [rqc_pkg::MAG_W-1:0]          rem_r;
  logic [rqc_pkg::QUO_W-1:0]          quo_r;
  logic [rqc_pkg::DIV_CNT_W-1:0]      cnt_r;

  logic [rqc_pkg::MAG_W:0]            rem_sh;
  logic                               fits;
  logic [rqc_pkg::QUO_W-1:0]          q_eff;
  logic [rqc_pkg::QUO_W-1:0]          base_ext;

  assign rem_sh = {rem_r, quo_r[rqc_pkg::QUO_W-1]};
  assign fits   = (rem_sh >= {1'b0, d_r});

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rqc_pkg::DV_IDLE: if (req.start) state_nxt = rqc_pkg::DV_MUL;
      rqc_pkg::DV_MUL:  state_nxt = rqc_pkg::DV_ADD;
      rqc_pkg::DV_ADD:  state_nxt = rqc_pkg::DV_PREP;
      rqc_pkg::DV_PREP: state_nxt = rqc_pkg::DV_DIV;
      rqc_pkg::DV_DIV:  if (cnt_r == '0) state_nxt = rqc_pkg::DV_DONE;
      rqc_pkg::DV_DONE: state_nxt = rqc_pkg::DV_IDLE;
      default:          state_nxt = rqc_pkg::DV_IDLE;
    endcase
  end

  // outputs: apply sign to the quotient, zero divisor gives the base
  always_comb begin
    q_eff     = (d_r == '0) ? '0 : quo_r;
    base_ext  = {{(rqc_pkg::QUO_W - rqc_pkg::COORD_W){base_r[rqc_pkg::COORD_W-1]}}, base_r};
    rsp.done  = (state_r == rqc_pkg::DV_DONE);
    rsp.value = neg_r ? rqc_pkg::COORD_W'(base_ext - q_eff)
                      : rqc_pkg::COORD_W'(base_ext + q_eff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rqc_pkg::DV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath: two-part product, then restoring division
  always_ff @(posedge clk) begin
    case (state_r)
      rqc_pkg::DV_IDLE: begin
        if (req.start) begin
          a_r    <= req.mag_a;
          b_r    <= req.mag_b;
          d_r    <= req.mag_d;
          neg_r  <= req.neg;
          base_r <= req.base;
        end
      end
      rqc_pkg::DV_MUL: begin
        prod_r <= rqc_pkg::PROD_W'(a_r[rqc_pkg::MAG_W-2:0]) * rqc_pkg::PROD_W'(b_r);
      end
      rqc_pkg::DV_ADD: begin
        if (a_r[rqc_pkg::MAG_W-1]) begin
          prod_r <= prod_r + {1'b0, b_r, 32'b0};
        end
      end
      rqc_pkg::DV_PREP: begin
        rem_r <= {1'b0, prod_r[rqc_pkg::PROD_W-1:rqc_pkg::QUO_W]};
        quo_r <= prod_r[rqc_pkg::QUO_W-1:0];
        cnt_r <= rqc_pkg::DIV_CNT_W'(rqc_pkg::QUO_W - 1);
      end
      rqc_pkg::DV_DIV: begin
        rem_r <= fits ? rqc_pkg::MAG_W'(rem_sh - {1'b0, d_r})
                      : rem_sh[rqc_pkg::MAG_W-1:0];
        quo_r <= {quo_r[rqc_pkg::QUO_W-2:0], fits};
        cnt_r <= cnt_r - rqc_pkg::DIV_CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

/* sv/rqc_back.sv */
// Clip engine: runs up to four half-plane passes and emits the polygon.
// Depends on rqc_pkg; drives the crossing-point unit rqc_div.
module rqc_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  input  rqc_pkg::quad_t                  q_data,
  output logic                            q_pop,
  output rqc_pkg::div_req_t               div_req,
  input  rqc_pkg::div_rsp_t               div_rsp,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [rqc_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                            out_tlast,
  output logic                            out_tuser
);

  localparam int NP = rqc_pkg::MAX_POINTS;
  localparam int IW = rqc_pkg::PT_IDX_W;
  localparam int CW = rqc_pkg::PT_CNT_W;

  rqc_pkg::back_state_t state_r, state_nxt;

  rqc_pkg::point_t               buf_r [2][NP];
  logic [rqc_pkg::HALF_W-1:0]    half_x_r, half_y_r;
  logic [1:0]                    stage_r;
  logic                          cb_r;
  logic [CW-1:0]                 ncur_r, nn_r;
  logic [IW-1:0]                 idx_r;
  logic                          cap_r;
  rqc_pkg::point_t               first_r, prev_r;

  logic                          out_valid_r;
  logic signed [31:0]            out_x_r, out_y_r;
  logic [IW-1:0]                 out_idx_r;
  logic                          out_last_r, out_empty_r;

  logic [IW-1:0]                 rd_idx;
  rqc_pkg::point_t               rd_pt, n_pt;
  logic                          last_edge;
  logic                          dir, negside;
  logic signed [32:0]            h, lim;
  logic signed [32:0]            p_d, p_o, n_d, n_o;
  logic                          pin, nin;
  logic signed [32:0]            dd, den;
  logic signed [33:0]            num;
  logic                          wr_en;
  rqc_pkg::point_t               wr_pt;
  rqc_pkg::point_t               cross_pt;
  logic                          out_load;
  logic                          emit_last;
  logic                          nn_full;

  // edge endpoints: previous vertex and the following one (wraps to first)
  always_comb begin
    unique case (state_r)
      rqc_pkg::BK_LOAD: rd_idx = '0;
      rqc_pkg::BK_EMIT: rd_idx = idx_r;
      default:          rd_idx = idx_r + IW'(1);
    endcase
  end
  assign rd_pt     = buf_r[cb_r][rd_idx];
  assign last_edge = ({1'b0, idx_r} + CW'(1)) == ncur_r;
  assign n_pt      = last_edge ? first_r : rd_pt;

  // clip line of this pass
  assign dir     = stage_r[1];
  assign negside = !stage_r[0];
  assign h       = dir ? $signed({2'b00, half_y_r}) : $signed({2'b00, half_x_r});
  assign lim     = negside ? -h : h;
  assign p_d     = dir ? 33'(prev_r.y) : 33'(prev_r.x);
  assign p_o     = dir ? 33'(prev_r.x) : 33'(prev_r.y);
  assign n_d     = dir ? 33'(n_pt.y) : 33'(n_pt.x);
  assign n_o     = dir ? 33'(n_pt.x) : 33'(n_pt.y);
  assign pin     = negside ? (p_d > lim) : (p_d < lim);
  assign nin     = negside ? (n_d > lim) : (n_d < lim);

  // crossing-point operands
  assign dd  = n_o - p_o;
  assign num = 34'(lim) - 34'(p_d);
  assign den = n_d - p_d;
  always_comb begin
    div_req.mag_a = dd[32] ? 33'(-dd) : 33'(dd);
    div_req.mag_b = num[33] ? 33'(-num) : 33'(num);
    div_req.mag_d = den[32] ? 33'(-den) : 33'(den);
    div_req.neg   = dd[32] ^ num[33] ^ den[32];
    div_req.base  = prev_r.x;
    if (!dir) begin
      div_req.base = prev_r.y;
    end
    div_req.start = (state_r == rqc_pkg::BK_EDGE) && (pin != nin) &&
                    !(pin && nn_full);
  end

  assign nn_full = (nn_r == CW'(NP - 1));

  // crossing point lies on the clip line
  always_comb begin
    cross_pt = '0;
    if (dir) begin
      cross_pt.y = lim[31:0];
      cross_pt.x = div_rsp.value;
    end else begin
      cross_pt.x = lim[31:0];
      cross_pt.y = div_rsp.value;
    end
  end

  // write of the next pass's polygon
  always_comb begin
    wr_en = 1'b0;
    wr_pt = prev_r;
    if (state_r == rqc_pkg::BK_EDGE && pin) begin
      wr_en = 1'b1;
    end else if (state_r == rqc_pkg::BK_WAIT && div_rsp.done) begin
      wr_en = 1'b1;
      wr_pt = cross_pt;
    end
  end

  assign out_load  = (state_r == rqc_pkg::BK_EMIT) && (!out_valid_r || out_tready);
  assign emit_last = (ncur_r == '0) || (({1'b0, idx_r} + CW'(1)) == ncur_r);
  assign q_pop     = (state_r == rqc_pkg::BK_IDLE) && q_valid;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rqc_pkg::BK_IDLE:  if (q_valid) state_nxt = rqc_pkg::BK_LOAD;
      rqc_pkg::BK_LOAD:  state_nxt = (ncur_r == '0) ? rqc_pkg::BK_EMIT : rqc_pkg::BK_EDGE;
      rqc_pkg::BK_EDGE: begin
        if (pin && nn_full)  state_nxt = rqc_pkg::BK_STAGE;
        else if (pin != nin) state_nxt = rqc_pkg::BK_WAIT;
        else                 state_nxt = rqc_pkg::BK_NEXT;
      end
      rqc_pkg::BK_WAIT: begin
        if (div_rsp.done) state_nxt = nn_full ? rqc_pkg::BK_STAGE : rqc_pkg::BK_NEXT;
      end
      rqc_pkg::BK_NEXT:  state_nxt = last_edge ? rqc_pkg::BK_STAGE : rqc_pkg::BK_EDGE;
      rqc_pkg::BK_STAGE: begin
        state_nxt = (cap_r || stage_r == 2'd3 || nn_r == CW'(NP)) ?
                    rqc_pkg::BK_EMIT : rqc_pkg::BK_LOAD;
      end
      rqc_pkg::BK_EMIT:  if (out_load && emit_last) state_nxt = rqc_pkg::BK_IDLE;
      default:           state_nxt = rqc_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rqc_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // pass bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= '0;
      cb_r    <= 1'b0;
      ncur_r  <= '0;
      nn_r    <= '0;
      idx_r   <= '0;
      cap_r   <= 1'b0;
    end else begin
      unique case (state_r)
        rqc_pkg::BK_IDLE: begin
          stage_r <= '0;
          cb_r    <= 1'b0;
          ncur_r  <= CW'(4);
          cap_r   <= 1'b0;
        end
        rqc_pkg::BK_LOAD: begin
          idx_r <= '0;
          nn_r  <= '0;
        end
        rqc_pkg::BK_EDGE: begin
          if (pin) nn_r <= nn_r + CW'(1);
          if (pin && nn_full) cap_r <= 1'b1;
        end
        rqc_pkg::BK_WAIT: begin
          if (div_rsp.done) begin
            nn_r <= nn_r + CW'(1);
            if (nn_full) cap_r <= 1'b1;
          end
        end
        rqc_pkg::BK_NEXT: begin
          idx_r <= idx_r + IW'(1);
        end
        rqc_pkg::BK_STAGE: begin
          ncur_r  <= nn_r;
          cb_r    <= !cb_r;
          stage_r <= stage_r + 2'd1;
          idx_r   <= '0;
        end
        rqc_pkg::BK_EMIT: begin
          if (out_load) idx_r <= idx_r + IW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // vertex storage and edge registers
  always_ff @(posedge clk) begin
    if (state_r == rqc_pkg::BK_IDLE && q_valid) begin
      half_x_r <= q_data.half_x;
      half_y_r <= q_data.half_y;
      for (int k = 0; k < 4; k++) begin
        buf_r[0][k].x <= q_data.corner_x[k];
        buf_r[0][k].y <= q_data.corner_y[k];
      end
    end
    if (wr_en) begin
      buf_r[!cb_r][nn_r[IW-1:0]] <= wr_pt;
    end
    if (state_r == rqc_pkg::BK_LOAD) begin
      first_r <= rd_pt;
      prev_r  <= rd_pt;
    end
    if (state_r == rqc_pkg::BK_NEXT) begin
      prev_r <= n_pt;
    end
  end

  // output register: holds a word until it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_idx_r   <= idx_r;
      out_last_r  <= emit_last;
      out_empty_r <= (ncur_r == '0);
      out_x_r     <= (ncur_r == '0) ? '0 : rd_pt.x;
      out_y_r     <= (ncur_r == '0) ? '0 : rd_pt.y;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_idx_r, out_y_r, out_x_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_empty_r;

endmodule

/* sv/rect_quad_clipper.sv */
// Top level of the rectangle quad clipper.
// Depends on rqc_pkg, rqc_front, rqc_div and rqc_back.
//
// Usage:
//   The in_ channel takes one word per quad: the rectangle half extents and
//   four corners. The block clips the quad against x > -hx, x < hx, y > -hy,
//   y < hy and sends the surviving vertices in order on the out_ channel, one
//   word per vertex, tlast on the final one. If nothing survives one word with
//   zero coordinates, tlast and tuser set is sent.
//   Throughput: one quad at a time in the clip engine. Each crossing point
//   is computed in the multiply/divide unit (one quotient bit per cycle)
//   while the engine waits for its result.
//   A small input queue accepts further quads while the engine works.
//   Reset (rst_n low, synchronous) empties the queue and idles the engine.
//   When the receiver stalls, the output register holds its word and the
//   engine waits; the input queue keeps filling until full.
module rect_quad_clipper #(
  parameter int QUEUE_DEPTH = rqc_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // half_x[30:0], half_y[61:31], corner0_x, corner0_y, corner1_x, corner1_y,
  // corner2_x, corner2_y, corner3_x, corner3_y (32 bits each), zero pad
  input  logic [rqc_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // point_x[31:0], point_y[63:32], point_index[66:64], zero pad
  output logic [rqc_pkg::OUT_DATA_W-1:0]  out_tdata,
  // is_last
  output logic                            out_tlast,
  // empty_result
  output logic                            out_tuser
);

  logic              q_valid;
  rqc_pkg::quad_t    q_data;
  logic              q_pop;
  rqc_pkg::div_req_t div_req;
  rqc_pkg::div_rsp_t div_rsp;

  rqc_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop)
  );

  rqc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  rqc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

/* sv/rqc_checker.sv */
// Port-level checks for the rectangle quad clipper, bound to the top level.
// Depends on rqc_pkg for the output word width.
module rqc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [rqc_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic                            out_tlast,
  input logic                            out_tuser
);

  logic [2:0] exp_idx_r;

  // track the expected vertex position within a polygon
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_idx_r <= '0;
    end else if (out_tvalid && out_tready) begin
      exp_idx_r <= out_tlast ? 3'd0 : exp_idx_r + 3'd1;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output word dropped while stalled");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && out_tdata[66:0] == 67'd0)
    else $error("empty result not a single zero word");

  a_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[66:64] == exp_idx_r)
    else $error("vertex index out of sequence");

  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[66:64] == 3'd7 |-> out_tlast)
    else $error("polygon longer than eight points");

endmodule

bind rect_quad_clipper rqc_checker u_rqc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

/* tb/rect_quad_clipper_test.sv */
// Self-checking testbench for rect_quad_clipper: drives quads on the input stream and
// checks every clipped vertex word against a built-in Sutherland-Hodgman predictor.
// Depends on rqc_pkg and the rect_quad_clipper RTL.
module rect_quad_clipper_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 400;
  localparam int Q16            = 1 << 16;

  typedef struct packed {
    logic [30:0]      hx;
    logic [30:0]      hy;
    logic [3:0][31:0] cx;
    logic [3:0][31:0] cy;
  } quad_s;

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [2:0]  idx;
    logic        last;
    logic        empty;
  } vertex_s;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [rqc_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [rqc_pkg::OUT_DATA_W-1:0] out_tdata;
  logic out_tlast;
  logic out_tuser;

  vertex_s clipped_q[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles   = 0;
  int mismatches    = 0;
  int quiet_cycles  = 0;

  rect_quad_clipper u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------- predictor ----------------
  function automatic logic [63:0] magnitude(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // other coordinate of the crossing point, offset truncated toward zero
  function automatic longint crossing(longint po, longint no, longint pd, longint nd,
                                      longint lim);
    longint d, num, den;
    logic [65:0] prod, quo;
    bit neg;
    d   = no - po;
    num = lim - pd;
    den = nd - pd;
    if (den == 0) return po;
    neg  = (d < 0) ^ (num < 0) ^ (den < 0);
    prod = 66'(magnitude(d)) * 66'(magnitude(num));
    quo  = prod / 66'(magnitude(den));
    return neg ? po - longint'(quo[63:0]) : po + longint'(quo[63:0]);
  endfunction

  // clip one quad and queue its vertex words
  function automatic void predict_clip(quad_s q);
    longint cur[8][2], nxt[8][2], half[2];
    longint h, lim;
    int ncur, nnxt, dir, oth, j;
    bit capped, negside, pin, nin;
    vertex_s v;
    ncur = 4;
    capped = 0;
    half[0] = longint'(q.hx);
    half[1] = longint'(q.hy);
    for (int i = 0; i < 4; i++) begin
      cur[i][0] = longint'(signed'(q.cx[i]));
      cur[i][1] = longint'(signed'(q.cy[i]));
    end
    for (int stage = 0; stage < 4 && !capped; stage++) begin
      dir = stage >> 1;
      oth = 1 - dir;
      negside = (stage & 1) == 0;
      h = half[dir];
      lim = negside ? -h : h;
      nnxt = 0;
      for (int i = 0; i < ncur && !capped; i++) begin
        j = (i + 1 < ncur) ? i + 1 : 0;
        pin = negside ? (-cur[i][dir] < h) : (cur[i][dir] < h);
        nin = negside ? (-cur[j][dir] < h) : (cur[j][dir] < h);
        if (pin) begin
          nxt[nnxt] = cur[i];
          nnxt++;
          if (nnxt >= 8) begin
            capped = 1;
            break;
          end
        end
        if (pin != nin) begin
          nxt[nnxt][oth] = crossing(cur[i][oth], cur[j][oth], cur[i][dir], cur[j][dir], lim);
          nxt[nnxt][dir] = lim;
          nnxt++;
          if (nnxt >= 8) capped = 1;
        end
      end
      for (int k = 0; k < nnxt; k++) cur[k] = nxt[k];
      ncur = nnxt;
    end
    if (ncur == 0) begin
      v = '{px: '0, py: '0, idx: '0, last: 1'b1, empty: 1'b1};
      clipped_q.push_back(v);
    end else begin
      for (int k = 0; k < ncur; k++) begin
        v = '{px: 32'(cur[k][0]), py: 32'(cur[k][1]), idx: 3'(k),
              last: (k == ncur - 1), empty: 1'b0};
        clipped_q.push_back(v);
      end
    end
  endfunction

  // ---------------- drivers ----------------
  task automatic send_quad(quad_s q);
    logic [rqc_pkg::IN_DATA_W-1:0] word;
    word = '0;
    word[30:0]  = q.hx;
    word[61:31] = q.hy;
    for (int k = 0; k < 4; k++) begin
      word[62 + 64*k +: 32] = q.cx[k];
      word[94 + 64*k +: 32] = q.cy[k];
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_clip(q);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // receiver: long hold-off when requested, random stalls otherwise
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare every accepted vertex word with the oldest prediction
  always @(posedge clk) begin
    vertex_s got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{px: out_tdata[31:0], py: out_tdata[63:32], idx: out_tdata[66:64],
              last: out_tlast, empty: out_tuser};
      if (clipped_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: x=%h y=%h idx=%0d last=%b empty=%b",
                                       got.px, got.py, got.idx, got.last, got.empty);
      end else begin
        want = clipped_q.pop_front();
        if (got !== want || out_tdata[71:67] !== '0) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp x=%h y=%h idx=%0d last=%b empty=%b, ",
                      "got x=%h y=%h idx=%0d last=%b empty=%b"},
                     want.px, want.py, want.idx, want.last, want.empty,
                     got.px, got.py, got.idx, got.last, got.empty);
        end
      end
    end
  end

  // watchdog: cycles with no word moving on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("rect_quad_clipper_test NOT OK");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  function automatic quad_s make_quad(int hx, int hy, int x0, int y0, int x1, int y1,
                                      int x2, int y2, int x3, int y3);
    quad_s q;
    q.hx = 31'(hx);
    q.hy = 31'(hy);
    q.cx = {32'(x3), 32'(x2), 32'(x1), 32'(x0)};
    q.cy = {32'(y3), 32'(y2), 32'(y1), 32'(y0)};
    return q;
  endfunction

  // mostly quads near the rectangle, some with raw full-range fields
  function automatic quad_s random_quad();
    quad_s q;
    int span, mode;
    mode = $urandom_range(9);
    q.hx = 31'($urandom_range(1, 16 * Q16));
    q.hy = (mode == 0) ? q.hx : 31'($urandom_range(1, 16 * Q16));
    span = 3 * ((q.hx > q.hy) ? q.hx : q.hy);
    for (int k = 0; k < 4; k++) begin
      q.cx[k] = 32'($urandom_range(0, 2 * span) - span);
      q.cy[k] = 32'($urandom_range(0, 2 * span) - span);
    end
    if (mode >= 8) begin
      q.hx = 31'($urandom);
      q.hy = 31'($urandom);
      for (int k = 0; k < 4; k++) begin
        q.cx[k] = $urandom;
        q.cy[k] = $urandom;
      end
    end
    return q;
  endfunction

  task automatic test_directed();
    int a, mx, mn;
    a = 10 * Q16;
    mx = 32'h7fffffff;
    mn = 32'h80000000;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // quad fully inside
    send_quad(make_quad(a, a, -Q16, -Q16, Q16, -Q16, Q16, Q16, -Q16, Q16));
    // quad fully outside
    send_quad(make_quad(a, a, 20*Q16, 0, 30*Q16, 0, 30*Q16, Q16, 20*Q16, Q16));
    // zero half extents
    send_quad(make_quad(0, a, 0, 0, Q16, 0, Q16, Q16, 0, Q16));
    send_quad(make_quad(a, 0, 0, 0, Q16, 0, Q16, Q16, 0, Q16));
    // quad covering the rectangle: rectangle corners come back
    send_quad(make_quad(a, a, -2*a, -2*a, 2*a, -2*a, 2*a, 2*a, -2*a, 2*a));
    // diamond cutting all four corners: point cap reached
    send_quad(make_quad(a, a, 0, -14*Q16, 14*Q16, 0, 0, 14*Q16, -14*Q16, 0));
    // vertices exactly on the boundary are outside
    send_quad(make_quad(a, a, -a, -a, a, -a, a, a, -a, a));
    send_quad(make_quad(a, a, -a, 0, 0, -a, a, 0, 0, a));
    // extreme coordinates and extents
    send_quad(make_quad(mx, mx, mn, mn, mx, mn, mx, mx, mn, mx));
    send_quad(make_quad(mx, 1, mn, mn, mx, mx, mn, mx, mx, mn));
    send_quad(make_quad(1, mx, 0, 0, 0, 0, 0, 0, 0, 0));
    send_quad(make_quad(mx, mx, mx, mx, mx, mx, mx, mx, mx, mx));
    // degenerate: all corners the same inside point
    send_quad(make_quad(a, a, 3, -5, 3, -5, 3, -5, 3, -5));
    // thin sliver crossing one side only
    send_quad(make_quad(a, a, 0, 0, 15*Q16, Q16, 15*Q16, 2*Q16, 0, 3*Q16));
    // skewed triangle-like quad, fractional values
    send_quad(make_quad(a + 7, a - 3, -11*Q16 + 5, 1, 9, -12*Q16 + 3, 12*Q16 - 1, 7,
                        -5, 13*Q16 + 9));
  endtask

  task automatic test_random(int n, int sp, int rp);
    send_idle_pct = sp;
    recv_idle_pct = rp;
    for (int i = 0; i < n; i++) send_quad(random_quad());
  endtask

  // receiver holds off while the sender keeps offering quads
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 1500;
    for (int i = 0; i < 12; i++) send_quad(random_quad());
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random(90, 38, 76);
    test_random(90, 76, 38);
    test_random(90, 0, 0);
    test_output_stall();
    test_random(20, 0, 0);
    while (clipped_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && clipped_q.size() == 0) begin
      $display("rect_quad_clipper_test OK");
    end else begin
      $display("rect_quad_clipper_test NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/rqc_pkg.sv
sv/rqc_front.sv
sv/rqc_div.sv
sv/rqc_back.sv
sv/rect_quad_clipper.sv
sv/rqc_checker.sv
tb/rect_quad_clipper_test.sv
